### rtl/twh_pkg.sv
// ----------------------------------------------------------------------------
// twh_pkg
// Shared types and constants for the threshold-binned weighted histogram.
// ----------------------------------------------------------------------------
package twh_pkg;

    localparam int THR_W      = 16;  // one threshold / forecast value
    localparam int NUM_THRESH = 12;  // thresholds held in the three packed words
    localparam int THR_PER_WD = 4;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int ROWS_W     = 4;
    localparam int WEIGHT_W   = 16;
    localparam int BIN_W      = 4;
    localparam int TOTAL_W    = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS     = 2'd0,
        REG_THRESHOLDS_A = 2'd1,
        REG_THRESHOLDS_B = 2'd2,
        REG_THRESHOLDS_C = 2'd3
    } t_reg_idx;

    typedef logic [THR_W-1:0] t_thr;
    typedef t_thr [NUM_THRESH-1:0] t_thr_vec;

    typedef struct packed {
        logic [THR_W-1:0]    value;
        logic                is_event;
        logic [WEIGHT_W-1:0] weight;
    } t_in_beat;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic               in_range;
        logic [TOTAL_W-1:0] event_total;
        logic [TOTAL_W-1:0] nonevent_total;
    } t_out_beat;

    // bin lookup result passed from the finder to the count stage
    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] bin;
    } t_bin_res;

endpackage

### rtl/twh_in_if.sv
// ----------------------------------------------------------------------------
// twh_in_if
// Valid/ready stream carrying one observation per beat.
// ----------------------------------------------------------------------------
interface twh_in_if
    import twh_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/twh_out_if.sv
// ----------------------------------------------------------------------------
// twh_out_if
// Valid/ready stream carrying one histogram update result per beat.
// ----------------------------------------------------------------------------
interface twh_out_if
    import twh_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/twh_bin_find.sv
// ----------------------------------------------------------------------------
// twh_bin_find
// Parallel threshold compare and lowest-match priority pick for one value.
// ----------------------------------------------------------------------------
module twh_bin_find
    import twh_pkg::*;
#(
    parameter int MAX_ROWS = 11
) (
    input  logic [THR_W-1:0]  i_value,
    input  t_thr_vec          i_thr,
    input  logic [ROWS_W-1:0] i_num_rows,
    output t_bin_res          o_res
);

    logic [ROWS_W-1:0]     rows;
    logic [NUM_THRESH-1:0] ge;
    logic [NUM_THRESH-1:0] lt;
    logic [MAX_ROWS-1:0]   match;
    t_thr                  top_thr;
    logic                  outside;

    // zero rows behaves as one, too many as MAX_ROWS
    always_comb begin
        if (i_num_rows == '0) begin
            rows = ROWS_W'(1);
        end else if (i_num_rows > ROWS_W'(MAX_ROWS)) begin
            rows = ROWS_W'(MAX_ROWS);
        end else begin
            rows = i_num_rows;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_THRESH; k++) begin
            ge[k] = (i_value >= i_thr[k]);
            lt[k] = (i_value <  i_thr[k]);
        end
        for (int j = 0; j < MAX_ROWS; j++) begin
            match[j] = (ROWS_W'(j) < rows) && ge[j] && lt[j+1];
        end
    end

    assign top_thr = i_thr[rows];
    assign outside = lt[0] || (i_value > top_thr);

    always_comb begin
        o_res.hit = 1'b0;
        o_res.bin = '0;
        for (int j = MAX_ROWS - 1; j >= 0; j--) begin
            if (match[j]) begin
                o_res.hit = 1'b1;
                o_res.bin = BIN_W'(j);
            end
        end
        // value sitting exactly on the top threshold lands in the last bin
        if (!o_res.hit && (i_value == top_thr)) begin
            o_res.hit = 1'b1;
            o_res.bin = BIN_W'(rows - ROWS_W'(1));
        end
        if (outside) begin
            o_res.hit = 1'b0;
            o_res.bin = '0;
        end
    end

endmodule

### rtl/threshold_bin_weighted_histogram.sv
// ----------------------------------------------------------------------------
// threshold_bin_weighted_histogram
// Weighted event / non-event histogram over programmable probability bins.
// ----------------------------------------------------------------------------
// One observation per clock is accepted unless the output stalls, and yields
// one result beat. It passes an input register, then a single stage that does
// the threshold compares, reads the bin's two counters, adds the weight with
// saturation, writes the counter back and loads the output register. Counters
// are flops cleared by reset, so no clearing pass is needed; back-to-back
// beats to the same bin see each other's updates. The user writes the
// thresholds and bin count via the config port while idle; nothing enforces it.
module threshold_bin_weighted_histogram
    import twh_pkg::*;
#(
    parameter int MAX_ROWS    = 11,
    parameter int COUNT_WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    twh_in_if.sink               i_in,
    twh_out_if.source            o_out
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EXT_W  = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

    // config
    logic [ROWS_W-1:0] r_num_rows;
    logic [CFG_W-1:0]  r_thr_a;
    logic [CFG_W-1:0]  r_thr_b;
    logic [CFG_W-1:0]  r_thr_c;
    t_thr_vec          thr;

    // pipeline
    logic     r_in_valid;
    t_in_beat r_in;
    logic     r_out_valid;
    t_out_beat r_out;
    logic     adv;
    logic     fire;

    // counters
    logic [COUNT_WIDTH-1:0] r_ev  [MAX_ROWS];
    logic [COUNT_WIDTH-1:0] r_nev [MAX_ROWS];

    t_bin_res               res;
    logic [ROW_AW-1:0]      row;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [COUNT_WIDTH-1:0] n_ev;
    logic [COUNT_WIDTH-1:0] n_nev;
    logic [EXT_W-1:0]       ext_ev;
    logic [EXT_W-1:0]       ext_nev;
    t_out_beat              n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= ROWS_W'(10);
            r_thr_a    <= '0;
            r_thr_b    <= '0;
            r_thr_c    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_NUM_ROWS:     r_num_rows <= i_cfg_data[ROWS_W-1:0];
                REG_THRESHOLDS_A: r_thr_a    <= i_cfg_data;
                REG_THRESHOLDS_B: r_thr_b    <= i_cfg_data;
                REG_THRESHOLDS_C: r_thr_c    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < THR_PER_WD; k++) begin
            thr[k]                = r_thr_a[k*THR_W +: THR_W];
            thr[k + THR_PER_WD]   = r_thr_b[k*THR_W +: THR_W];
            thr[k + 2*THR_PER_WD] = r_thr_c[k*THR_W +: THR_W];
        end
    end

    // stage moves when the output register is free or being drained
    assign adv         = !r_out_valid || o_out.ready;
    assign fire        = r_in_valid && adv;
    assign i_in.ready  = !r_in_valid || adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    twh_bin_find #(
        .MAX_ROWS (MAX_ROWS)
    ) u_bin_find (
        .i_value    (r_in.value),
        .i_thr      (thr),
        .i_num_rows (r_num_rows),
        .o_res      (res)
    );

    assign row = res.bin[ROW_AW-1:0];
    assign cur = r_in.is_event ? r_ev[row] : r_nev[row];
    assign sum = {1'b0, cur} + (COUNT_WIDTH+1)'(r_in.weight);
    // carry out means the count pinned at full scale
    assign n_cnt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    assign n_ev  = r_in.is_event ? n_cnt : r_ev[row];
    assign n_nev = r_in.is_event ? r_nev[row] : n_cnt;

    assign ext_ev  = EXT_W'(n_ev);
    assign ext_nev = EXT_W'(n_nev);

    always_comb begin
        n_out = '0;
        if (res.hit) begin
            n_out.bin            = res.bin;
            n_out.in_range       = 1'b1;
            n_out.event_total    = ext_ev[TOTAL_W-1:0];
            n_out.nonevent_total = ext_nev[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_ROWS; j++) begin
                r_ev[j]  <= '0;
                r_nev[j] <= '0;
            end
        end else if (fire && res.hit) begin
            r_ev[row]  <= n_ev;
            r_nev[row] <= n_nev;
        end
    end

    // a result beat never reports a bin past the last row
    a_bin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.in_range |-> r_out.bin < BIN_W'(MAX_ROWS))
        else $error("result bin beyond last row");

    // out-of-range results carry zero totals
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.in_range |->
            r_out.event_total == '0 && r_out.nonevent_total == '0 && r_out.bin == '0)
        else $error("out-of-range result with nonzero fields");

    // an update never makes a counter smaller
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.hit |=> r_ev[$past(row)] >= $past(r_ev[row])
            && r_nev[$past(row)] >= $past(r_nev[row]))
        else $error("bin counter decreased");

    // a stalled full input stage must not take a new beat
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |-> !i_in.ready)
        else $error("input taken while stage is blocked");

    // reset leaves the first bin's counters cleared
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_ev[0] == '0 && r_nev[0] == '0)
        else $error("counters not cleared by reset");

endmodule
